// File: hdl/lph_pkg.sv
// lph_pkg: shared types and constants of the linear-probe hash table
// status codes, control state encoding, memory command group, hash constants
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lph_pkg;

    // key layout
    localparam int KEY_LOW_W  = 64;
    localparam int KEY_HIGH_W = 32;
    localparam int KEY_W      = KEY_LOW_W + KEY_HIGH_W;
    localparam int KEY_MAX_BYTES = KEY_W / 8;

    // result field widths
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 8;

    // murmur3 finaliser
    localparam logic [31:0] FMIX_C1 = 32'h85ebca6b;
    localparam logic [31:0] FMIX_C2 = 32'hc2b2ae35;
    localparam int          FMIX_SH_A = 16;
    localparam int          FMIX_SH_B = 13;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_FOUND     = 3'd0,
        STATUS_NOT_FOUND = 3'd1,
        STATUS_INSERTED  = 3'd2,
        STATUS_DUPLICATE = 3'd3,
        STATUS_FULL      = 3'd4,
        STATUS_INVALID   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_HASH,
        FSM_PROBE,
        FSM_DELIVER
    } fsm_state_t;

    typedef enum logic {
        KIND_LOOKUP = 1'b0,
        KIND_INSERT = 1'b1
    } kind_t;

    typedef struct packed {
        logic rd_en;
        logic key_wr_en;
        logic val_wr_en;
    } mem_cmd_t;

endpackage

`default_nettype wire

// File: hdl/lph_hash.sv
// lph_hash: key normalisation, murmur3 fmix32 and reduction to a home slot
// multi-cycle unit, started by a pulse, answers with a one-cycle done pulse
// depends on lph_pkg
`timescale 1ns / 1ps
`default_nettype none

module lph_hash import lph_pkg::*; #(
    parameter int TABLE_SLOTS = 256,
    parameter int KEY_BYTES   = 12,
    parameter int IDX_W       = 8
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   start,
    input  wire  [KEY_LOW_W-1:0]  key_low,
    input  wire  [KEY_HIGH_W-1:0] key_high,
    output logic                  done,
    output logic [IDX_W-1:0]      home,
    output logic [KEY_LOW_W-1:0]  norm_key_low,
    output logic [KEY_HIGH_W-1:0] norm_key_high
);

    localparam bit IS_POW2 = ((64'd1 << IDX_W) == 64'(TABLE_SLOTS));

    logic [KEY_W-1:0] raw_key;
    logic [KEY_W-1:0] norm_key;
    logic             live;

    logic [KEY_W-1:0] key_reg;
    logic [31:0]      h0_reg;
    logic [31:0]      p1_reg;
    logic [31:0]      p2_reg;
    logic [31:0]      h3_reg;
    logic [3:0]       vld_reg;

    // cut the key at its first zero byte and at KEY_BYTES
    assign raw_key = {key_high, key_low};

    always_comb begin
        live     = 1'b1;
        norm_key = '0;
        for (int i = 0; i < KEY_MAX_BYTES; i++) begin
            if (raw_key[8*i +: 8] == 8'h00 || i >= KEY_BYTES) begin
                live = 1'b0;
            end
            norm_key[8*i +: 8] = live ? raw_key[8*i +: 8] : 8'h00;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[2:0], start};
        end
    end

    // fmix32, at most one multiply per stage
    always_ff @(posedge aclk) begin
        if (start) begin
            key_reg <= norm_key;
            h0_reg  <= norm_key[31:0] ^ (norm_key[31:0] >> FMIX_SH_A);
        end
        if (vld_reg[0]) begin
            p1_reg <= h0_reg * FMIX_C1;
        end
        if (vld_reg[1]) begin
            p2_reg <= (p1_reg ^ (p1_reg >> FMIX_SH_B)) * FMIX_C2;
        end
        if (vld_reg[2]) begin
            h3_reg <= p2_reg ^ (p2_reg >> FMIX_SH_A);
        end
    end

    assign norm_key_low  = key_reg[KEY_LOW_W-1:0];
    assign norm_key_high = key_reg[KEY_W-1:KEY_LOW_W];

    generate
        if (IS_POW2) begin : g_mask
            assign done = vld_reg[3];
            assign home = h3_reg[IDX_W-1:0];
        end else begin : g_rem
            // floor(2^(32+IDX_W) / TABLE_SLOTS), 33 bits with the top bit set
            localparam logic [63:0] RECIP = (64'd1 << (32 + IDX_W)) / 64'(TABLE_SLOTS);
            localparam logic [31:0] MOD_N = 32'(TABLE_SLOTS);

            logic [3:0]       rv_reg;
            logic [31:0]      h_reg;
            logic [63:0]      prod_reg;
            logic [31:0]      quot_reg;
            logic [31:0]      qn_reg;
            logic [IDX_W-1:0] rem_reg;
            logic [64:0]      prod_sum;
            logic [31:0]      diff;

            // reciprocal multiply, quotient low by at most one, fixed by one subtract
            assign prod_sum = {1'b0, prod_reg} + {1'b0, h_reg, 32'd0};
            assign diff     = h_reg - qn_reg;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    rv_reg <= '0;
                end else begin
                    rv_reg <= {rv_reg[2:0], vld_reg[3]};
                end
            end

            always_ff @(posedge aclk) begin
                if (vld_reg[3]) begin
                    h_reg    <= h3_reg;
                    prod_reg <= 64'(h3_reg) * 64'(RECIP[31:0]);
                end
                if (rv_reg[0]) begin
                    quot_reg <= 32'(prod_sum >> (32 + IDX_W));
                end
                if (rv_reg[1]) begin
                    qn_reg <= quot_reg * MOD_N;
                end
                if (rv_reg[2]) begin
                    rem_reg <= (diff >= MOD_N) ? IDX_W'(diff - MOD_N) : IDX_W'(diff);
                end
            end

            assign done = rv_reg[3];
            assign home = rem_reg;
        end
    endgenerate

endmodule

`default_nettype wire

// File: hdl/lph_mem.sv
// lph_mem: slot storage, key memory and value memory, registered read
// one read and one write address per cycle, value zero marks an empty slot
// depends on lph_pkg
`timescale 1ns / 1ps
`default_nettype none

module lph_mem import lph_pkg::*; #(
    parameter int TABLE_SLOTS = 256,
    parameter int IDX_W       = 8,
    parameter int VALUE_BITS  = 6
) (
    input  wire                   aclk,
    input  mem_cmd_t              cmd,
    input  wire  [IDX_W-1:0]      rd_addr,
    input  wire  [IDX_W-1:0]      wr_addr,
    input  wire  [KEY_W-1:0]      wr_key,
    input  wire  [VALUE_BITS-1:0] wr_value,
    output logic [KEY_W-1:0]      rd_key,
    output logic [VALUE_BITS-1:0] rd_value
);

    logic [KEY_W-1:0]      key_mem [TABLE_SLOTS];
    logic [VALUE_BITS-1:0] val_mem [TABLE_SLOTS];

    always_ff @(posedge aclk) begin
        if (cmd.key_wr_en) begin
            key_mem[wr_addr] <= wr_key;
        end
        if (cmd.rd_en) begin
            rd_key <= key_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.val_wr_en) begin
            val_mem[wr_addr] <= wr_value;
        end
        if (cmd.rd_en) begin
            rd_value <= val_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/linear_probe_hash_table.sv
// linear_probe_hash_table: open-addressing key/value table with linear probing
// top level, control sequencer and result register
// depends on lph_pkg, lph_hash, lph_mem
//
// usage
//   s_ channel takes one request item: s_kind (0 lookup, 1 insert), a 12-byte
//   key in s_key_low/s_key_high (byte 0 in bits 7:0) and s_value for inserts
//   m_ channel returns one result item per request: m_status, m_found_value
//   and m_slot (low 8 bits of the slot index)
//   the home slot is the murmur3 fmix32 of key bytes 0..3 modulo TABLE_SLOTS
// timing
//   one request at a time; the pipelined hash passes through its fmix32 registers
//   (and then the remainder unit when TABLE_SLOTS is not a power of two), then the
//   probe walks one slot per cycle through the memory read port
//   a request that resolves at its home slot passes through HASH, PROBE and
//   DELIVER, and the next item is taken back in IDLE; each further probe
//   stays in PROBE for one more slot read; an insert with value zero skips
//   the hash and the probe and goes from IDLE straight to DELIVER
// reset
//   aresetn clears the control; a clearing pass then writes every value entry
//   to empty, with s_ready held low throughout
// back-pressure
//   a finished result sits in the output register until m_ready; the next
//   request is still taken meanwhile and waits before its own delivery
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_table import lph_pkg::*; #(
    parameter int TABLE_SLOTS = 256,
    parameter int KEY_BYTES   = 12,
    parameter int VALUE_BITS  = 6
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    // request channel
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire                   s_kind,
    input  wire  [KEY_LOW_W-1:0]  s_key_low,
    input  wire  [KEY_HIGH_W-1:0] s_key_high,
    input  wire  [VALUE_BITS-1:0] s_value,
    // result channel
    output logic                  m_valid,
    input  wire                   m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [VALUE_BITS-1:0] m_found_value,
    output logic [SLOT_W-1:0]     m_slot
);

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

    // control state
    fsm_state_t state_reg, state_next;
    logic [IDX_W-1:0] clr_idx_reg, clr_idx_next;
    logic [IDX_W-1:0] probe_idx_reg, probe_idx_next;
    logic [IDX_W-1:0] probe_cnt_reg, probe_cnt_next;
    kind_t            kind_reg, kind_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;

    // result waiting for the output register
    status_t               res_status_reg, res_status_next;
    logic [VALUE_BITS-1:0] res_value_reg, res_value_next;
    logic [IDX_W-1:0]      res_slot_reg, res_slot_next;

    // output register
    logic                  m_valid_reg, m_valid_next;
    status_t               m_status_reg, m_status_next;
    logic [VALUE_BITS-1:0] m_found_value_reg, m_found_value_next;
    logic [SLOT_W-1:0]     m_slot_reg, m_slot_next;

    // hash unit
    logic                  hash_start;
    logic                  hash_done;
    logic [IDX_W-1:0]      hash_home;
    logic [KEY_LOW_W-1:0]  norm_key_low;
    logic [KEY_HIGH_W-1:0] norm_key_high;

    // memory
    mem_cmd_t              mem_cmd;
    logic [IDX_W-1:0]      mem_rd_addr;
    logic [IDX_W-1:0]      mem_wr_addr;
    logic [VALUE_BITS-1:0] mem_wr_value;
    logic [KEY_W-1:0]      mem_rd_key;
    logic [VALUE_BITS-1:0] mem_rd_value;

    logic [IDX_W-1:0] probe_step_idx;
    logic             slot_used;
    logic             key_match;
    logic             out_free;

    lph_hash #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BYTES   (KEY_BYTES),
        .IDX_W       (IDX_W)
    ) u_hash (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (hash_start),
        .key_low       (s_key_low),
        .key_high      (s_key_high),
        .done          (hash_done),
        .home          (hash_home),
        .norm_key_low  (norm_key_low),
        .norm_key_high (norm_key_high)
    );

    lph_mem #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .IDX_W       (IDX_W),
        .VALUE_BITS  (VALUE_BITS)
    ) u_mem (
        .aclk     (aclk),
        .cmd      (mem_cmd),
        .rd_addr  (mem_rd_addr),
        .wr_addr  (mem_wr_addr),
        .wr_key   ({norm_key_high, norm_key_low}),
        .wr_value (mem_wr_value),
        .rd_key   (mem_rd_key),
        .rd_value (mem_rd_value)
    );

    // next probe position, wrapping at the end of the table
    assign probe_step_idx = (probe_idx_reg == LAST_IDX) ? '0 : probe_idx_reg + IDX_W'(1);

    // memory data in PROBE belongs to probe_idx_reg
    assign slot_used = (mem_rd_value != '0);
    assign key_match = slot_used && (mem_rd_key == {norm_key_high, norm_key_low});
    assign out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_CLEAR;
            clr_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        probe_idx_reg     <= probe_idx_next;
        probe_cnt_reg     <= probe_cnt_next;
        kind_reg          <= kind_next;
        value_reg         <= value_next;
        res_status_reg    <= res_status_next;
        res_value_reg     <= res_value_next;
        res_slot_reg      <= res_slot_next;
        m_status_reg      <= m_status_next;
        m_found_value_reg <= m_found_value_next;
        m_slot_reg        <= m_slot_next;
    end

    always_comb begin
        state_next         = state_reg;
        clr_idx_next       = clr_idx_reg;
        probe_idx_next     = probe_idx_reg;
        probe_cnt_next     = probe_cnt_reg;
        kind_next          = kind_reg;
        value_next         = value_reg;
        res_status_next    = res_status_reg;
        res_value_next     = res_value_reg;
        res_slot_next      = res_slot_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_status_next      = m_status_reg;
        m_found_value_next = m_found_value_reg;
        m_slot_next        = m_slot_reg;

        s_ready      = 1'b0;
        hash_start   = 1'b0;
        mem_cmd      = '0;
        mem_rd_addr  = probe_step_idx;
        mem_wr_addr  = probe_idx_reg;
        mem_wr_value = value_reg;

        case (state_reg)
            FSM_CLEAR: begin
                // sweep every value entry to empty
                mem_cmd.val_wr_en = 1'b1;
                mem_wr_addr       = clr_idx_reg;
                mem_wr_value      = '0;
                clr_idx_next      = clr_idx_reg + IDX_W'(1);
                if (clr_idx_reg == LAST_IDX) begin
                    state_next = FSM_IDLE;
                end
            end

            FSM_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    kind_next  = kind_t'(s_kind);
                    value_next = s_value;
                    if (s_kind == KIND_INSERT && s_value == '0) begin
                        // zero value would read back as empty
                        res_status_next = STATUS_INVALID;
                        res_value_next  = '0;
                        res_slot_next   = '0;
                        state_next      = FSM_DELIVER;
                    end else begin
                        hash_start = 1'b1;
                        state_next = FSM_HASH;
                    end
                end
            end

            FSM_HASH: begin
                if (hash_done) begin
                    mem_cmd.rd_en  = 1'b1;
                    mem_rd_addr    = hash_home;
                    probe_idx_next = hash_home;
                    probe_cnt_next = '0;
                    state_next     = FSM_PROBE;
                end
            end

            FSM_PROBE: begin
                res_value_next = '0;
                res_slot_next  = '0;
                if (!slot_used) begin
                    if (kind_reg == KIND_INSERT) begin
                        mem_cmd.key_wr_en = 1'b1;
                        mem_cmd.val_wr_en = 1'b1;
                        res_status_next   = STATUS_INSERTED;
                        res_slot_next     = probe_idx_reg;
                    end else begin
                        res_status_next = STATUS_NOT_FOUND;
                    end
                    state_next = FSM_DELIVER;
                end else if (key_match) begin
                    if (kind_reg == KIND_INSERT) begin
                        res_status_next = STATUS_DUPLICATE;
                    end else begin
                        res_status_next = STATUS_FOUND;
                        res_value_next  = mem_rd_value;
                        res_slot_next   = probe_idx_reg;
                    end
                    state_next = FSM_DELIVER;
                end else if (probe_cnt_reg == LAST_IDX) begin
                    // one full pass without a hit
                    res_status_next = (kind_reg == KIND_INSERT) ? STATUS_FULL
                                                                : STATUS_NOT_FOUND;
                    state_next = FSM_DELIVER;
                end else begin
                    // read ahead of the slot just ruled out
                    mem_cmd.rd_en  = 1'b1;
                    probe_idx_next = probe_step_idx;
                    probe_cnt_next = probe_cnt_reg + IDX_W'(1);
                end
            end

            FSM_DELIVER: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_status_next      = res_status_reg;
                    m_found_value_next = res_value_reg;
                    m_slot_next        = SLOT_W'(res_slot_reg);
                    state_next         = FSM_IDLE;
                end
            end

            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_found_value = m_found_value_reg;
    assign m_slot        = m_slot_reg;

endmodule

`default_nettype wire

// File: hdl/lph_checker.sv
// lph_checker: port-level checks of the linear-probe hash table
// bound to the top level below
// depends on lph_pkg
`timescale 1ns / 1ps
`default_nettype none

module lph_checker import lph_pkg::*; #(
    parameter int VALUE_BITS = 6
) (
    input wire                  aclk,
    input wire                  aresetn,
    input wire                  s_valid,
    input wire                  s_ready,
    input wire                  m_valid,
    input wire                  m_ready,
    input wire [STATUS_W-1:0]   m_status,
    input wire [VALUE_BITS-1:0] m_found_value,
    input wire [SLOT_W-1:0]     m_slot
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_found_value) && $stable(m_slot))
        else $error("result item changed while stalled");

    // the request channel is closed right after reset, as the clearing pass starts
    a_reset_closed: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("request taken during clearing pass");

    // a found key always carries a nonzero value
    a_found_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_FOUND |-> m_found_value != '0)
        else $error("found item with empty value");

    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_FOUND |-> m_found_value == '0)
        else $error("value reported without a hit");

    a_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STATUS_NOT_FOUND || m_status == STATUS_DUPLICATE
            || m_status == STATUS_FULL || m_status == STATUS_INVALID)
        |-> m_slot == '0)
        else $error("slot reported without a hit or insert");

endmodule

bind linear_probe_hash_table lph_checker #(.VALUE_BITS(VALUE_BITS)) u_lph_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_found_value (m_found_value),
    .m_slot        (m_slot)
);

`default_nettype wire

// File: tb/linear_probe_hash_table_test.sv
// linear_probe_hash_table_test: self-checking bench for the linear-probe hash table
// carries its own table model and result scoreboard, drives both handshake channels
// depends on lph_pkg and linear_probe_hash_table
`timescale 1ns / 1ps

// one expected result item, tagged with the number of the request that caused it
typedef struct packed {
    int                  item_no;
    lph_pkg::status_t    status;
    logic [5:0]          found_value;
    logic [7:0]          slot;
} table_result_t;

// model of the slot store plus the queue of results still owed by the block
class probe_table_model;
    localparam int SLOTS = 256;

    logic [95:0]   slot_key [SLOTS];
    logic [5:0]    slot_value [SLOTS];
    logic [95:0]   stored_keys [$];
    table_result_t pending_results [$];
    int            accepted;
    int            mismatches;

    function new();
        int i;
        for (i = 0; i < SLOTS; i++) begin
            slot_key[i]   = '0;
            slot_value[i] = '0;
        end
        accepted   = 0;
        mismatches = 0;
    endfunction

    // number of bytes before the first zero byte
    static function int key_length(logic [95:0] k);
        int n;
        n = 0;
        while (n < 12 && k[8*n +: 8] != 8'h00)
            n++;
        return n;
    endfunction

    static function logic [95:0] normalise(logic [95:0] k);
        logic [95:0] n;
        int          len;
        int          i;
        n   = '0;
        len = key_length(k);
        for (i = 0; i < len; i++)
            n[8*i +: 8] = k[8*i +: 8];
        return n;
    endfunction

    static function logic [31:0] fmix(logic [31:0] h);
        h = h ^ (h >> lph_pkg::FMIX_SH_A);
        h = h * lph_pkg::FMIX_C1;
        h = h ^ (h >> lph_pkg::FMIX_SH_B);
        h = h * lph_pkg::FMIX_C2;
        h = h ^ (h >> lph_pkg::FMIX_SH_A);
        return h;
    endfunction

    // walk the table for one accepted request and queue the result it owes
    function void note_request(lph_pkg::kind_t kind, logic [95:0] raw, logic [5:0] val);
        logic [95:0]   key;
        int unsigned   pos;
        int            n;
        table_result_t r;
        key           = normalise(raw);
        pos           = fmix(key[31:0]) % SLOTS;
        r.item_no     = accepted;
        r.found_value = '0;
        r.slot        = '0;
        accepted++;
        if (kind == lph_pkg::KIND_INSERT) begin
            if (val == '0) begin
                r.status = lph_pkg::STATUS_INVALID;
            end else begin
                r.status = lph_pkg::STATUS_FULL;
                for (n = 0; n < SLOTS; n++) begin
                    if (slot_value[pos] == '0) begin
                        slot_key[pos]   = key;
                        slot_value[pos] = val;
                        stored_keys     = {stored_keys, key};
                        r.status = lph_pkg::STATUS_INSERTED;
                        r.slot   = pos[7:0];
                        break;
                    end
                    if (slot_key[pos] == key) begin
                        r.status = lph_pkg::STATUS_DUPLICATE;
                        break;
                    end
                    pos = (pos + 1) % SLOTS;
                end
            end
        end else begin
            r.status = lph_pkg::STATUS_NOT_FOUND;
            for (n = 0; n < SLOTS; n++) begin
                if (slot_value[pos] == '0)
                    break;
                if (slot_key[pos] == key) begin
                    r.status      = lph_pkg::STATUS_FOUND;
                    r.found_value = slot_value[pos];
                    r.slot        = pos[7:0];
                    break;
                end
                pos = (pos + 1) % SLOTS;
            end
        end
        pending_results = {pending_results, r};
    endfunction

    task report_mismatch(int item_no, string field, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= 50)
            $display("mismatch on item %0d: %s is %0d, expected %0d",
                     item_no, field, got, want);
    endtask

    task check_result(logic [2:0] status, logic [5:0] found_value, logic [7:0] slot);
        table_result_t want;
        if (pending_results.size() == 0) begin
            report_mismatch(-1, "unexpected result, status", 32'(status), 32'd0);
        end else begin
            want = pending_results.pop_front();
            if (status !== want.status)
                report_mismatch(want.item_no, "status", 32'(status), 32'(want.status));
            if (found_value !== want.found_value)
                report_mismatch(want.item_no, "found_value", 32'(found_value),
                                32'(want.found_value));
            if (slot !== want.slot)
                report_mismatch(want.item_no, "slot", 32'(slot), 32'(want.slot));
        end
    endtask
endclass

module linear_probe_hash_table_test;
    import lph_pkg::*;

    localparam int RANDOM_ITEMS = 1880;
    localparam int STALL_LIMIT  = 4000;  // cycles with no item moving on either side
    localparam int DRAIN_CYCLES = 300;   // one full probe pass plus hash latency

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    wire         s_ready;
    logic        s_kind        = 1'b0;
    logic [63:0] s_key_low     = '0;
    logic [31:0] s_key_high    = '0;
    logic [5:0]  s_value       = '0;
    wire         m_valid;
    logic        m_ready       = 1'b0;
    wire  [2:0]  m_status;
    wire  [5:0]  m_found_value;
    wire  [7:0]  m_slot;

    probe_table_model model;
    logic [31:0]      family_prefix [3];  // shared first four bytes, so shared home slot
    bit               quiet = 1'b0;       // no idling on either side while set
    int               stall_cycles = 0;

    wire request_taken = s_valid && s_ready;
    wire result_taken  = m_valid && m_ready;

    linear_probe_hash_table u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_key_low     (s_key_low),
        .s_key_high    (s_key_high),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found_value (m_found_value),
        .m_slot        (m_slot)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // result side: values seen here are the ones present at this edge
    always @(posedge aclk) begin
        if (aresetn && result_taken)
            model.check_result(m_status, m_found_value, m_slot);
        m_ready <= quiet || ($urandom_range(0, 99) >= 19);
    end

    // watchdog: the longest legal gap is the clearing pass or one full probe pass
    always @(posedge aclk) begin
        if (request_taken || result_taken)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // bytes after the terminator are random half of the time
    function automatic logic [95:0] garble_tail(logic [95:0] k);
        int len;
        int i;
        len = model.key_length(k);
        if ($urandom_range(0, 1) == 1)
            for (i = len + 1; i < 12; i++)
                k[8*i +: 8] = 8'($urandom);
        return k;
    endfunction

    // new random key of any length; a family key shares a prefix with others
    function automatic logic [95:0] fresh_key(bit family);
        logic [95:0] k;
        int          len;
        int          i;
        k   = '0;
        len = family ? $urandom_range(4, 12) : $urandom_range(0, 12);
        for (i = 0; i < len; i++)
            k[8*i +: 8] = 8'($urandom_range(1, 255));
        if (family)
            k[31:0] = family_prefix[$urandom_range(0, 2)];
        return garble_tail(k);
    endfunction

    function automatic logic [95:0] known_key();
        return model.stored_keys[$urandom_range(0, model.stored_keys.size() - 1)];
    endfunction

    // a stored key made one byte longer (or with its last byte changed)
    function automatic logic [95:0] near_miss(logic [95:0] k);
        int len;
        len = model.key_length(k);
        if (len < 12)
            k[8*len +: 8] = 8'($urandom_range(1, 255));
        else
            k[95:88] = k[95:88] ^ 8'h01;
        return garble_tail(k);
    endfunction

    // present one request item and hold it until taken; valid stays high on return
    // so a following item can go out back to back when no idle gap is drawn
    task automatic send_request(input kind_t kind, input logic [95:0] key,
                                input logic [5:0] val);
        if (!quiet && $urandom_range(0, 99) < 19) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 19);
        end
        s_valid    <= 1'b1;
        s_kind     <= kind;
        s_key_low  <= key[63:0];
        s_key_high <= key[95:64];
        s_value    <= val;
        do @(posedge aclk); while (!s_ready);
        model.note_request(kind, key, val);
    endtask

    initial begin
        int item;
        int pick;
        int i;
        model = new();
        for (i = 0; i < 3; i++)
            family_prefix[i] = {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                                8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty key, zero value, all-ones key, terminator handling,
        // shared home slot chains, full-length keys, top bits set
        send_request(KIND_LOOKUP, 96'h0, 6'd0);
        send_request(KIND_INSERT, 96'h0, 6'd0);
        send_request(KIND_INSERT, {32'hffff_ffff, 64'hffff_ffff_ffff_ffff}, 6'd63);
        send_request(KIND_LOOKUP, {32'hffff_ffff, 64'hffff_ffff_ffff_ffff}, 6'd0);
        send_request(KIND_INSERT, {32'hffff_ffff, 64'hffff_ffff_ffff_ffff}, 6'd5);
        // terminator in byte 0: the empty key, whatever follows
        send_request(KIND_INSERT, {32'hffff_ffff, 64'hffff_ffff_ffff_ff00}, 6'd1);
        send_request(KIND_LOOKUP, 96'h0, 6'd63);
        send_request(KIND_INSERT, {32'h1234_5678, 64'h00ab_cd00_4433_2211}, 6'd2);
        send_request(KIND_LOOKUP, {32'h0, 64'h0000_0000_4433_2211}, 6'd0);
        // same first four bytes, so same home slot: walks the chain
        send_request(KIND_INSERT, {32'h0, 64'h0000_0055_4433_2211}, 6'd3);
        send_request(KIND_INSERT, {32'h0, 64'h0000_6655_4433_2211}, 6'd4);
        send_request(KIND_LOOKUP, {32'hdead_beef, 64'h9900_0055_4433_2211}, 6'd0);
        send_request(KIND_LOOKUP, {32'h0, 64'h0000_0077_4433_2211}, 6'd0);
        send_request(KIND_INSERT, {32'h0, 64'h0000_0055_4433_2211}, 6'd0);
        send_request(KIND_INSERT, {32'h0c0b_0a09, 64'h0807_0605_0403_0201}, 6'd42);
        send_request(KIND_LOOKUP, {32'h000b_0a09, 64'h0807_0605_0403_0201}, 6'd0);
        send_request(KIND_LOOKUP, {32'h0c0b_0a09, 64'h0807_0605_0403_0201}, 6'd21);
        send_request(KIND_INSERT, {32'h8080_8080, 64'h8080_8080_8080_8080}, 6'd33);
        send_request(KIND_LOOKUP, {32'h8080_8080, 64'h8080_8080_8080_8080}, 6'd0);

        // random: new inserts fill the table about two thirds of the way through,
        // so the later part sees a full table and exhausted lookups
        for (item = 0; item < RANDOM_ITEMS; item++) begin
            quiet = (item >= 700 && item < 1000);
            pick  = $urandom_range(0, 99);
            if (pick < 22 || model.stored_keys.size() == 0)
                send_request(KIND_INSERT, fresh_key($urandom_range(0, 99) < 40),
                             6'($urandom_range(1, 63)));
            else if (pick < 32)
                // mostly duplicates, now and then a zero value
                send_request(KIND_INSERT, garble_tail(known_key()), 6'($urandom));
            else if (pick < 36)
                send_request(KIND_INSERT, fresh_key($urandom_range(0, 1) == 1), 6'd0);
            else if (pick < 71)
                send_request(KIND_LOOKUP, garble_tail(known_key()), 6'($urandom));
            else if (pick < 85)
                send_request(KIND_LOOKUP, fresh_key($urandom_range(0, 1) == 1),
                             6'($urandom));
            else
                send_request(KIND_LOOKUP, near_miss(known_key()), 6'($urandom));
        end
        quiet = 1'b0;
        s_valid <= 1'b0;

        while (model.pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (model.mismatches == 0 && model.pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
